FILE: hdl/emb_pkg.sv
// Package for the 3x3 emboss filter: pixel and column types, field widths,
// register indexes, the emboss kernel and the clamp function.
// No dependencies.
package emb_pkg;

  // Fixed field widths.
  localparam int CHAN_W    = 8;
  localparam int CHANNELS  = 3;
  localparam int PIX_W     = CHAN_W * CHANNELS;
  localparam int CFG_W     = 13;
  localparam int IMG_W_W   = 12;
  localparam int IMG_H_W   = 13;
  localparam int ROW_OUT_W = 12;
  localparam int COL_OUT_W = 11;
  localparam int SUM_W     = 12;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  // Register indexes of the configuration port.
  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // One pixel; channel 0 (red) sits in the lowest bits.
  typedef logic [CHANNELS-1:0][CHAN_W-1:0] pix_t;

  // One window column: the pixel two rows up, one row up and the current row.
  typedef struct packed {
    pix_t cur;
    pix_t mid;
    pix_t up;
  } column_t;

  // Signed partial sums, one per channel.
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef sum_t [CHANNELS-1:0] sums_t;

  // Position and end-of-frame flag that travel with a result.
  typedef struct packed {
    logic                 last;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
  } tag_t;

  // Emboss kernel, indexed [row][column]; row 0 is the oldest line,
  // column 0 the oldest pixel.
  localparam int KERNEL [3][3] = '{'{-2, -1, 0}, '{-1, 1, 1}, '{0, 1, 2}};

  // Clamps a signed sum to the range of one channel.
  function automatic logic [CHAN_W-1:0] clamp_byte(input sum_t s);
    logic [CHAN_W-1:0] r;
    if (s < 0) begin
      r = '0;
    end else if (s > sum_t'(255)) begin
      r = '1;
    end else begin
      r = s[CHAN_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/emboss_convolution_3x3_rgb.sv
// Top level of the streaming 3x3 emboss filter for RGB pixels.
// Depends on emb_pkg, emb_ram (two line stores) and emb_cell (window chain).
//
//  Channel | Signals                          | Carries
//  --------+----------------------------------+----------------------------------
//  s_*     | s_tvalid s_tready s_tdata        | input pixels in raster order
//  m_*     | m_tvalid m_tready m_tdata m_tlast| filtered interior pixels
//  cfg_*   | cfg_we cfg_index cfg_data        | image width and height writes
//
// One pixel is accepted per clock cycle while the output does not stall; the
// figure is set by the single read and single write per cycle of each line
// store. A result follows the pixel below-right of it through the line store
// read and the window shift, then is clamped into the output register.
// Reset is synchronous; it clears the counters, the valid flags and the
// sizes (512 by 512). The line stores need no clearing pass. A stalled
// output blocks the input in the same cycle once both stages are full;
// behind the held result one more result waits in the window and one pixel
// waits in the line store stage.
module emboss_convolution_3x3_rgb #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  // Fields from bit 0: in_red, in_green, in_blue.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [emb_pkg::IN_DATA_W-1:0]  s_tdata,
  // Fields from bit 0: out_red, out_green, out_blue, centre_row,
  // centre_col, one zero pad bit.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [emb_pkg::OUT_DATA_W-1:0] m_tdata,
  // frame_last.
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [emb_pkg::IDX_W-1:0]      cfg_index,
  input  logic [emb_pkg::CFG_W-1:0]      cfg_data
);
  import emb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int RESET_WM1 = ((MAX_WIDTH < 512) ? MAX_WIDTH : 512) - 1;
  localparam int RESET_HM1 = ((MAX_HEIGHT < 512) ? MAX_HEIGHT : 512) - 1;

  // Sizes in use, stored as last index, and the raster counters.
  logic [CW-1:0] width_m1;
  logic [CW-1:0] width_m1_next;
  logic [RW-1:0] height_m1;
  logic [RW-1:0] height_m1_next;
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;

  // Stage 1: line store read is in flight.
  logic          s1_valid;
  pix_t          s1_pix;
  logic [CW-1:0] s1_col;
  logic          s1_emit;
  tag_t          s1_tag;
  tag_t          tag_next;

  // Stage 2: the window holds a result that waits for the output register.
  logic          s2_valid;
  tag_t          s2_tag;

  // Handshake chain.
  logic          accept;
  logic          out_free;
  logic          s2_adv;
  logic          s2_open;
  logic          s1_adv;
  logic          col_last;
  logic          row_last;

  pix_t          up_rd;
  pix_t          mid_rd;
  column_t       chain_col [4];
  sums_t         chain_sum [4];
  logic [PIX_W-1:0] out_pix;

  // Ready ripples back from the output register through both stages.
  assign out_free = !m_tvalid || m_tready;
  assign s2_adv   = s2_valid && out_free;
  assign s2_open  = !s2_valid || s2_adv;
  assign s1_adv   = s1_valid && s2_open;
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  assign col_last = (col_count == width_m1);
  assign row_last = (row_count == height_m1);

  // Saturate a written size to the supported range.
  always_comb begin
    logic [31:0] w_raw;
    logic [31:0] h_raw;
    w_raw = 32'(cfg_data[IMG_W_W-1:0]);
    h_raw = 32'(cfg_data[IMG_H_W-1:0]);
    if (w_raw < 32'd3) begin
      width_m1_next = CW'(2);
    end else if (w_raw > 32'(MAX_WIDTH)) begin
      width_m1_next = CW'(MAX_WIDTH - 1);
    end else begin
      width_m1_next = CW'(w_raw - 32'd1);
    end
    if (h_raw < 32'd3) begin
      height_m1_next = RW'(2);
    end else if (h_raw > 32'(MAX_HEIGHT)) begin
      height_m1_next = RW'(MAX_HEIGHT - 1);
    end else begin
      height_m1_next = RW'(h_raw - 32'd1);
    end
  end

  // Size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_m1  <= CW'(RESET_WM1);
      height_m1 <= RW'(RESET_HM1);
    end else if (cfg_we) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        width_m1 <= width_m1_next;
      end
      if (cfg_index == REG_IMAGE_HEIGHT) begin
        height_m1 <= height_m1_next;
      end
    end
  end

  // Raster counters; a size write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
                            cfg_index == REG_IMAGE_HEIGHT)) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_count <= '0;
        row_count <= row_last ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  // Position of the centre pixel, one row up and one column left.
  always_comb begin
    logic [31:0] row_m1;
    logic [31:0] col_m1;
    row_m1        = 32'(row_count) - 32'd1;
    col_m1        = 32'(col_count) - 32'd1;
    tag_next.row  = row_m1[ROW_OUT_W-1:0];
    tag_next.col  = col_m1[COL_OUT_W-1:0];
    tag_next.last = row_last && col_last;
  end

  // Stage 1 control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= pix_t'(s_tdata[PIX_W-1:0]);
      s1_col  <= col_count;
      s1_emit <= (row_count >= RW'(2)) && (col_count >= CW'(2));
      s1_tag  <= tag_next;
    end
  end

  // Line stores: read at acceptance, written back when the pixel moves on.
  emb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (mid_rd),
    .re    (accept),
    .raddr (col_count),
    .rdata (up_rd)
  );

  emb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_middle (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (accept),
    .raddr (col_count),
    .rdata (mid_rd)
  );

  // Window chain: cell 2 takes the new column, cell 0 holds the oldest.
  assign chain_col[3] = '{cur: s1_pix, mid: mid_rd, up: up_rd};
  assign chain_sum[0] = '0;

  for (genvar k = 0; k < 3; k++) begin : g_cell
    emb_cell #(
      .COL (k)
    ) u_cell (
      .clk     (clk),
      .en      (s1_adv),
      .col_in  (chain_col[k+1]),
      .sum_in  (chain_sum[k]),
      .col_out (chain_col[k]),
      .sum_out (chain_sum[k+1])
    );
  end

  // Stage 2 control: only pixels that yield a result occupy it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= s1_emit;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_tag <= s1_tag;
    end
  end

  // Clamp each channel of the full window sum.
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      out_pix[ch*CHAN_W +: CHAN_W] = clamp_byte(chain_sum[3][ch]);
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      m_tdata <= {1'b0, s2_tag.col, s2_tag.row, out_pix};
      m_tlast <= s2_tag.last;
    end
  end

  // An empty first stage always takes a pixel.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_tready)
    else $error("input stalled with an empty first stage");

  // An accepted pixel is in the first stage on the next cycle.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel lost before the line store read");

  // Write-back and a new read never touch the same line store entry.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && accept) |-> (s1_col != col_count))
    else $error("line store read and write at the same column");

  // A waiting result stays in the window while the output is blocked.
  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !out_free) |=> (s2_valid && $stable(s2_tag)))
    else $error("pending result overwritten while the output stalled");

  // The window does not shift under a result that has not moved on.
  a_no_shift_under_result: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_adv) |-> !s1_adv)
    else $error("window shifted under a pending result");

endmodule

FILE: hdl/emb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while the read enable is low. No dependencies.
module emb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/emb_cell.sv
// One cell of the window chain: holds one 3-pixel column, passes it to the
// older neighbor on each shift, and adds its kernel column to the running sum.
// Depends on emb_pkg.
module emb_cell #(
  parameter int COL = 0
) (
  input  logic             clk,
  input  logic             en,
  input  emb_pkg::column_t col_in,
  input  emb_pkg::sums_t   sum_in,
  output emb_pkg::column_t col_out,
  output emb_pkg::sums_t   sum_out
);
  import emb_pkg::*;

  column_t col_q;

  // The column shifts in from the newer neighbor.
  always_ff @(posedge clk) begin
    if (en) begin
      col_q <= col_in;
    end
  end

  assign col_out = col_q;

  // Weighted column sum per channel, added to the sum of the older cells.
  always_comb begin
    int acc;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      acc = int'(sum_in[ch])
          + KERNEL[0][COL] * int'(col_q.up[ch])
          + KERNEL[1][COL] * int'(col_q.mid[ch])
          + KERNEL[2][COL] * int'(col_q.cur[ch]);
      sum_out[ch] = SUM_W'(acc);
    end
  end

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the streaming 3x3 RGB emboss filter.
// Depends on emb_pkg and the emboss_convolution_3x3_rgb RTL; a built-in
// predictor computes the expected filtered pixels and compares every result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import emb_pkg::*;

  localparam int LINE_DEPTH  = 2048;
  localparam int ROWS_MAX    = 4096;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 12;

  // Register indexes that the block does not decode.
  localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Emboss weights in raster order of the window: top row first, oldest column first.
  localparam int EMBOSS_WEIGHT [9] = '{-2, -1, 0, -1, 1, 1, 0, 1, 2};

  // Idle percentages per traffic mode: none, sender, receiver, both.
  localparam int SENDER_IDLE [4]   = '{0, 74, 0, 14};
  localparam int RECEIVER_IDLE [4] = '{0, 0, 74, 14};

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [10:0] col;
    logic        last;
  } embossed_pixel_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  // Stimulus and expectation stores.
  logic [23:0]     pixels_to_send [$];
  embossed_pixel_t embossed_due [$];
  int              sender_idle_pct = 0;
  int              receiver_stall_pct = 0;
  int              error_count = 0;
  int              cycle_count = 0;
  embossed_pixel_t oldest_due;

  // Predictor state: line stores, window, counters and register copies.
  logic [23:0] upper_line [LINE_DEPTH];
  logic [23:0] middle_line [LINE_DEPTH];
  logic [23:0] window [9];
  int unsigned col_pos;
  int unsigned row_pos;
  logic [11:0] width_reg;
  logic [12:0] height_reg;

  emboss_convolution_3x3_rgb dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Tracks a register write; width or height writes restart the frame.
  task automatic track_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = data[11:0];
      col_pos = 0;
      row_pos = 0;
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = data;
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  // Advances the line stores and the window by one pixel and queues the
  // filtered centre pixel when the window covers an interior position.
  task automatic predict_emboss(input logic [23:0] pix);
    int unsigned w, h, c, r;
    logic [23:0] up, mid;
    embossed_pixel_t res;
    logic [7:0] chan [3];
    int acc;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    h = height_reg;
    if (h < 3) h = 3;
    if (h > ROWS_MAX) h = ROWS_MAX;
    c = col_pos;
    r = row_pos;
    up = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = pix;
    for (int k = 0; k < 3; k++) begin
      window[k*3]   = window[k*3+1];
      window[k*3+1] = window[k*3+2];
    end
    window[2] = up;
    window[5] = mid;
    window[8] = pix;
    if (r >= 2 && c >= 2) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc = 0;
        for (int i = 0; i < 9; i++) begin
          acc += int'(window[i][ch*8 +: 8]) * EMBOSS_WEIGHT[i];
        end
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        chan[ch] = acc[7:0];
      end
      res.red   = chan[0];
      res.green = chan[1];
      res.blue  = chan[2];
      res.row   = 12'(r - 1);
      res.col   = 11'(c - 1);
      res.last  = (r + 1 >= h) && (c + 1 >= w);
      embossed_due.push_back(res);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Pixel driver: offers queued pixels and runs the predictor on each transaction.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) window[i] = '0;
      col_pos = 0;
      row_pos = 0;
      width_reg = 12'd512;
      height_reg = 13'd512;
    end else begin
      if (cfg_we) track_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) predict_emboss(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pixels_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= pixels_to_send.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Result monitor: applies back-pressure and checks each transaction in order.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (embossed_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got data %h last %b",
                   $time, m_tdata, m_tlast);
          error_count++;
        end else begin
          oldest_due = embossed_due.pop_front();
          // m_tdata from bit 0: red, green, blue, row, col, pad.
          compare_field("out_red",    oldest_due.red,   m_tdata[7:0]);
          compare_field("out_green",  oldest_due.green, m_tdata[15:8]);
          compare_field("out_blue",   oldest_due.blue,  m_tdata[23:16]);
          compare_field("centre_row", oldest_due.row,   m_tdata[35:24]);
          compare_field("centre_col", oldest_due.col,   m_tdata[46:36]);
          compare_field("frame_last", oldest_due.last,  m_tlast);
        end
      end
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[emboss_convolution_3x3_rgb] ERROR");
      $finish;
    end
  end

  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every pixel is sent and every result is back, then lets the
  // pipeline empty of pixels that produce no result.
  task automatic wait_drained();
    do @(negedge clk);
    while (pixels_to_send.size() != 0 || s_tvalid || embossed_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One traffic phase: optional register writes, then a run of random pixels.
  task automatic run_phase(input bit wr_width, input logic [CFG_W-1:0] width_val,
                           input bit wr_height, input logic [CFG_W-1:0] height_val,
                           input bit wr_spare, input int count, input int mode);
    logic [23:0] pix;
    sender_idle_pct = SENDER_IDLE[mode];
    receiver_stall_pct = RECEIVER_IDLE[mode];
    if (wr_width) write_register(REG_IMAGE_WIDTH, width_val);
    if (wr_height) write_register(REG_IMAGE_HEIGHT, height_val);
    if (wr_spare) begin
      write_register(REG_SPARE_A, CFG_W'($urandom()));
      write_register(REG_SPARE_B, CFG_W'($urandom()));
    end
    for (int i = 0; i < count; i++) begin
      // Saturated pixels now and then push the sums to both clamp limits.
      if ($urandom_range(7) == 0) begin
        pix = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
      end else begin
        pix = 24'($urandom());
      end
      pixels_to_send.push_back(pix);
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: two 3x3 frames that drive each channel into opposite clamps.
    write_register(REG_IMAGE_WIDTH, 13'd3);
    write_register(REG_IMAGE_HEIGHT, 13'd3);
    for (int i = 0; i < 9; i++) begin
      pixels_to_send.push_back(EMBOSS_WEIGHT[i] < 0 ? 24'h0000FF :
                               EMBOSS_WEIGHT[i] > 0 ? 24'hFFFF00 : 24'hFFFFFF);
    end
    for (int i = 0; i < 9; i++) begin
      pixels_to_send.push_back(EMBOSS_WEIGHT[i] < 0 ? 24'hFFFF00 :
                               EMBOSS_WEIGHT[i] > 0 ? 24'h0000FF : 24'h000000);
    end
    wait_drained();

    // Random phases; width bit 12 is ignored and sizes saturate to their range.
    run_phase(1, 13'h1003, 1, 13'd4, 0, 50, 0);
    run_phase(1, 13'd5, 1, 13'd3, 1, 60, 1);
    run_phase(1, 13'd0, 1, 13'd0, 0, 45, 2);
    run_phase(1, 13'd7, 1, 13'd5, 0, 33, 3);
    // Only undecoded registers written: the frame carries on.
    run_phase(0, 13'd0, 0, 13'd0, 1, 40, 1);
    run_phase(1, 13'd3, 1, 13'h1FFF, 0, 60, 2);
    run_phase(1, 13'd2, 1, 13'd6, 0, 40, 0);
    // Widest row: the start of a saturated row, then a restart by the next write.
    run_phase(1, 13'h1FFF, 1, 13'd3, 0, 10, 0);
    run_phase(1, 13'd10, 0, 13'd0, 0, 60, 3);
    run_phase(0, 13'd0, 1, 13'd6, 0, 50, 1);
    for (int p = 0; p < 4; p++) begin
      run_phase(1, CFG_W'($urandom_range(3, 16)), 1, CFG_W'($urandom_range(3, 8)),
                $urandom_range(1), $urandom_range(10, 25), p);
    end

    if (error_count == 0) begin
      $display("[emboss_convolution_3x3_rgb] OK");
    end else begin
      $display("[emboss_convolution_3x3_rgb] ERROR");
    end
    $finish;
  end

endmodule
